### rtl/eil_pkg.sv
// Shared types and constants for the ISO-BMFF EXIF locator.
// Holds the walk phase encoding, the result beat layout, outcome codes and
// the fixed EXIF lead sequence. No dependencies.
`default_nettype none

package eil_pkg;

  typedef enum logic [6:0] {
    PH_TOP_HDR  = 7'b0000001,
    PH_TOP_SKIP = 7'b0000010,
    PH_IN_HDR   = 7'b0000100,
    PH_IN_SKIP  = 7'b0001000,
    PH_SEARCH   = 7'b0010000,
    PH_EMIT     = 7'b0100000,
    PH_DONE     = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [2:0] code;
  } result_t;

  localparam logic [2:0] CODE_EXIF      = 3'd0;
  localparam logic [2:0] CODE_NO_OUTER  = 3'd1;
  localparam logic [2:0] CODE_BAD_OUTER = 3'd2;
  localparam logic [2:0] CODE_NO_INNER  = 3'd3;
  localparam logic [2:0] CODE_NO_TIFF   = 3'd4;

  localparam logic [1:0] REG_FILE_LENGTH = 2'd0;
  localparam logic [1:0] REG_OUTER_TYPE  = 2'd1;
  localparam logic [1:0] REG_INNER_TYPE  = 2'd2;

  localparam int unsigned CFG_BITS = 48;

  localparam logic [31:0] TYPE_MOOV = 32'h6D6F6F76;
  localparam logic [31:0] TYPE_UUID = 32'h75756964;

  // 'I','I',42 as seen in the three most recent bytes
  localparam logic [23:0] TIFF_MARK = 24'h49492A;

  localparam logic [4:0] HDR_NONE = 5'd0;
  localparam logic [4:0] HDR_EXT  = 5'd1;
  localparam logic [4:0] HDR_LEN  = 5'd8;
  localparam logic [4:0] HDR_LONG = 5'd16;

  localparam logic [3:0] LEAD_LAST = 4'd9;

  // 'E','x','i','f',0,0 then the TIFF header 'I','I',42,0
  function automatic logic [7:0] lead_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h45;
      4'd1:    b = 8'h78;
      4'd2:    b = 8'h69;
      4'd3:    b = 8'h66;
      4'd6:    b = 8'h49;
      4'd7:    b = 8'h49;
      4'd8:    b = 8'h2A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

### rtl/eil_skid.sv
// Two-entry result buffer: an output register plus one skid slot.
// Depends on eil_pkg for the result beat layout.
`default_nettype none

module eil_skid (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  eil_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  wire              out_ready,
  output eil_pkg::result_t out_data
);

  eil_pkg::result_t slot0;
  eil_pkg::result_t slot1;
  logic [1:0]       count;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case (count)
        2'd0: begin
          if (push) count <= 2'd1;
        end
        2'd1: begin
          if (push && !pop) count <= 2'd2;
          else if (!push && pop) count <= 2'd0;
        end
        2'd2: begin
          if (pop) count <= 2'd1;
        end
        default: count <= 2'd0;
      endcase
    end
  end

  // payload: refill the head from the skid slot or straight from the push
  always_ff @(posedge clk) begin
    if (count == 2'd2) begin
      if (pop) slot0 <= slot1;
    end else if (push) begin
      if (count == 2'd0 || pop) slot0 <= push_data;
      else slot1 <= push_data;
    end
  end

endmodule

`default_nettype wire

### rtl/isobmff_exif_locator.sv
// Top level of the ISO-BMFF EXIF locator: box walk, TIFF search and lead burst.
// Depends on eil_pkg and eil_skid.
`default_nettype none

// Feed the file one byte per beat on in_byte. The block walks the top-level
// boxes for outer_box_type, walks that box's children for inner_box_type and
// scans the child's content for the TIFF header 'I','I',42,0. On a hit it
// sends 'E','x','i','f',0,0, the TIFF header and the rest of the child box,
// with last high on the final beat; any failure gives one beat with last
// high, out_byte zero and a nonzero outcome. After file_length bytes the walk
// restarts for the next file. Rate: one input beat per clock while the output
// buffer has room; each byte is handled in the cycle it is accepted, and its
// result lands in a two-entry output buffer. The other exception is a TIFF
// hit: that byte yields ten beats, and input holds off while the other
// nine leave by the single output port. Write registers only while the block is
// idle; writes take effect at once and do not restart the walk.
module isobmff_exif_locator #(
  parameter int unsigned POSITION_BITS = 48
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [7:0]                     in_byte,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [7:0]                     out_byte,
  output logic                           last,
  output logic [2:0]                     outcome,
  input  wire                            cfg_write,
  input  wire  [1:0]                     cfg_index,
  input  wire  [eil_pkg::CFG_BITS-1:0]   cfg_data
);

  localparam int unsigned P = POSITION_BITS;

  // configuration
  logic [P-1:0] file_length;
  logic [31:0]  outer_box_type;
  logic [31:0]  inner_box_type;
  logic [63:0]  cfg_wide;

  // walk state
  eil_pkg::phase_t phase, phase_next;
  logic [P-1:0]    file_position, file_position_next;
  logic [3:0]      header_count, header_count_next;
  logic [63:0]     box_size, box_size_next;
  logic [31:0]     box_type, box_type_next;
  logic [P-1:0]    skip_left, skip_left_next;
  logic [P-1:0]    outer_content_left, outer_content_left_next;
  logic [P-1:0]    inner_content_left, inner_content_left_next;
  logic [23:0]     recent_bytes, recent_bytes_next;

  // lead burst counter: zero when idle, else index of the next lead beat
  logic [3:0] lead_idx, lead_idx_next;

  logic accept;
  logic buf_full;
  logic buf_push;
  eil_pkg::result_t buf_data;
  eil_pkg::result_t buf_head;

  logic             res_valid;
  eil_pkg::result_t res;
  logic             hit;

  // header byte intake, shared by both header phases
  logic [63:0]  ht_size;
  logic [31:0]  ht_type;
  logic [4:0]   ht_r;
  logic [63:0]  content;
  logic [P-1:0] pos_inc;
  logic [P-1:0] room_now;
  logic [P-1:0] room_inc;
  logic [P-1:0] outer_dec;
  logic [P-1:0] skip_dec;
  logic [P-1:0] inner_dec;

  function automatic logic [P-1:0] room_from(input logic [P-1:0] n,
                                             input logic [P-1:0] len);
    return (n < len) ? (len - n) : '0;
  endfunction

  assign cfg_wide = 64'(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      file_length    <= P'(1);
      outer_box_type <= eil_pkg::TYPE_MOOV;
      inner_box_type <= eil_pkg::TYPE_UUID;
    end else if (cfg_write) begin
      case (cfg_index)
        eil_pkg::REG_FILE_LENGTH: file_length    <= cfg_wide[P-1:0];
        eil_pkg::REG_OUTER_TYPE:  outer_box_type <= cfg_data[31:0];
        eil_pkg::REG_INNER_TYPE:  inner_box_type <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (lead_idx == 4'd0) && !buf_full;
  assign accept   = in_valid && in_ready;

  assign pos_inc   = file_position + P'(1);
  assign room_now  = room_from(file_position, file_length);
  assign room_inc  = room_from(pos_inc, file_length);
  assign outer_dec = (outer_content_left != '0) ? outer_content_left - P'(1) : '0;
  assign skip_dec  = (skip_left != '0) ? skip_left - P'(1) : '0;
  assign inner_dec = (inner_content_left != '0) ? inner_content_left - P'(1) : '0;

  // bytes 4..7 of a header are the type, all others feed the size
  always_comb begin
    ht_size = box_size;
    ht_type = box_type;
    if (header_count[3:2] == 2'b01) ht_type = {box_type[23:0], in_byte};
    else ht_size = {box_size[55:0], in_byte};
    if (header_count == 4'd7) ht_r = (ht_size == 64'd1) ? eil_pkg::HDR_EXT : eil_pkg::HDR_LEN;
    else if (header_count == 4'd15) ht_r = eil_pkg::HDR_LONG;
    else ht_r = eil_pkg::HDR_NONE;
    content = ht_size - 64'(ht_r);
  end

  always_comb begin
    phase_next              = phase;
    file_position_next      = pos_inc;
    header_count_next       = header_count;
    box_size_next           = box_size;
    box_type_next           = box_type;
    skip_left_next          = skip_left;
    outer_content_left_next = outer_content_left;
    inner_content_left_next = inner_content_left;
    recent_bytes_next       = recent_bytes;
    res_valid               = 1'b0;
    res                     = '{data: 8'h00, last: 1'b1, code: eil_pkg::CODE_EXIF};
    hit                     = 1'b0;

    case (phase)
      eil_pkg::PH_TOP_HDR: begin
        if (header_count == 4'd0 && room_now < P'(8)) begin
          res_valid = 1'b1;
          res.code = eil_pkg::CODE_NO_OUTER;
          phase_next = eil_pkg::PH_DONE;
        end else begin
          header_count_next = header_count + 4'd1;
          box_size_next     = ht_size;
          box_type_next     = ht_type;
          if (ht_r == eil_pkg::HDR_EXT) begin
            if (room_inc < P'(8)) begin
              res_valid = 1'b1;
              res.code = eil_pkg::CODE_NO_OUTER;
              phase_next = eil_pkg::PH_DONE;
            end else begin
              box_size_next = '0;
            end
          end else if (ht_r != eil_pkg::HDR_NONE) begin
            if (ht_size < 64'(ht_r) || content > 64'(room_inc)) begin
              res_valid = 1'b1;
              res.code = eil_pkg::CODE_BAD_OUTER;
              phase_next = eil_pkg::PH_DONE;
            end else if (ht_type == outer_box_type) begin
              outer_content_left_next = content[P-1:0];
              if (content < 64'd8) begin
                res_valid = 1'b1;
                res.code = eil_pkg::CODE_NO_INNER;
                phase_next = eil_pkg::PH_DONE;
              end else begin
                phase_next = eil_pkg::PH_IN_HDR;
                header_count_next = '0;
                box_size_next = '0;
                box_type_next = '0;
              end
            end else if (content == 64'd0) begin
              if (room_inc < P'(8)) begin
                res_valid = 1'b1;
                res.code = eil_pkg::CODE_NO_OUTER;
                phase_next = eil_pkg::PH_DONE;
              end else begin
                header_count_next = '0;
                box_size_next = '0;
                box_type_next = '0;
              end
            end else begin
              skip_left_next = content[P-1:0];
              phase_next = eil_pkg::PH_TOP_SKIP;
            end
          end
        end
      end

      eil_pkg::PH_TOP_SKIP: begin
        skip_left_next = skip_dec;
        if (skip_dec == '0) begin
          if (room_inc < P'(8)) begin
            res_valid = 1'b1;
            res.code = eil_pkg::CODE_NO_OUTER;
            phase_next = eil_pkg::PH_DONE;
          end else begin
            phase_next = eil_pkg::PH_TOP_HDR;
            header_count_next = '0;
            box_size_next = '0;
            box_type_next = '0;
          end
        end
      end

      eil_pkg::PH_IN_HDR: begin
        outer_content_left_next = outer_dec;
        header_count_next = header_count + 4'd1;
        box_size_next     = ht_size;
        box_type_next     = ht_type;
        if (ht_r == eil_pkg::HDR_EXT) begin
          if (outer_dec < P'(8)) begin
            res_valid = 1'b1;
            res.code = eil_pkg::CODE_NO_INNER;
            phase_next = eil_pkg::PH_DONE;
          end else begin
            box_size_next = '0;
          end
        end else if (ht_r != eil_pkg::HDR_NONE) begin
          if (ht_size < 64'(ht_r) || content > 64'(outer_dec)) begin
            res_valid = 1'b1;
            res.code = eil_pkg::CODE_NO_INNER;
            phase_next = eil_pkg::PH_DONE;
          end else if (ht_type == inner_box_type) begin
            inner_content_left_next = content[P-1:0];
            recent_bytes_next = '0;
            if (content == 64'd0) begin
              res_valid = 1'b1;
              res.code = eil_pkg::CODE_NO_TIFF;
              phase_next = eil_pkg::PH_DONE;
            end else begin
              phase_next = eil_pkg::PH_SEARCH;
            end
          end else if (content == 64'd0) begin
            if (outer_dec < P'(8)) begin
              res_valid = 1'b1;
              res.code = eil_pkg::CODE_NO_INNER;
              phase_next = eil_pkg::PH_DONE;
            end else begin
              header_count_next = '0;
              box_size_next = '0;
              box_type_next = '0;
            end
          end else begin
            skip_left_next = content[P-1:0];
            phase_next = eil_pkg::PH_IN_SKIP;
          end
        end
      end

      eil_pkg::PH_IN_SKIP: begin
        outer_content_left_next = outer_dec;
        skip_left_next = skip_dec;
        if (skip_dec == '0) begin
          if (outer_dec < P'(8)) begin
            res_valid = 1'b1;
            res.code = eil_pkg::CODE_NO_INNER;
            phase_next = eil_pkg::PH_DONE;
          end else begin
            phase_next = eil_pkg::PH_IN_HDR;
            header_count_next = '0;
            box_size_next = '0;
            box_type_next = '0;
          end
        end
      end

      eil_pkg::PH_SEARCH: begin
        inner_content_left_next = inner_dec;
        // the header counts only when at least one content byte follows it
        if (recent_bytes == eil_pkg::TIFF_MARK && in_byte == 8'h00 && inner_dec != '0) begin
          hit = 1'b1;
          res_valid = 1'b1;
          res = '{data: eil_pkg::lead_byte(4'd0), last: 1'b0, code: eil_pkg::CODE_EXIF};
          phase_next = eil_pkg::PH_EMIT;
        end else begin
          recent_bytes_next = {recent_bytes[15:0], in_byte};
          if (inner_dec == '0) begin
            res_valid = 1'b1;
            res.code = eil_pkg::CODE_NO_TIFF;
            phase_next = eil_pkg::PH_DONE;
          end
        end
      end

      eil_pkg::PH_EMIT: begin
        inner_content_left_next = inner_dec;
        res_valid = 1'b1;
        res = '{data: in_byte, last: (inner_dec == '0), code: eil_pkg::CODE_EXIF};
        if (inner_dec == '0) phase_next = eil_pkg::PH_DONE;
      end

      default: ;  // done: drop bytes until the file ends
    endcase

    // end of file: restart the walk for the next one
    if (pos_inc >= file_length) begin
      phase_next              = eil_pkg::PH_TOP_HDR;
      file_position_next      = '0;
      header_count_next       = '0;
      box_size_next           = '0;
      box_type_next           = '0;
      skip_left_next          = '0;
      outer_content_left_next = '0;
      inner_content_left_next = '0;
      recent_bytes_next       = '0;
    end
  end

  // lead burst: the first lead beat goes out with the hit byte, the rest
  // follow one per cycle while the buffer has room and input holds off
  always_comb begin
    lead_idx_next = lead_idx;
    if (accept && hit) lead_idx_next = 4'd1;
    else if (lead_idx != 4'd0 && !buf_full)
      lead_idx_next = (lead_idx == eil_pkg::LEAD_LAST) ? 4'd0 : lead_idx + 4'd1;
  end

  always_comb begin
    if (accept) begin
      buf_push = res_valid;
      buf_data = res;
    end else begin
      buf_push = (lead_idx != 4'd0) && !buf_full;
      buf_data = '{data: eil_pkg::lead_byte(lead_idx), last: 1'b0,
                   code: eil_pkg::CODE_EXIF};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= eil_pkg::PH_TOP_HDR;
      file_position      <= '0;
      header_count       <= '0;
      box_size           <= '0;
      box_type           <= '0;
      skip_left          <= '0;
      outer_content_left <= '0;
      inner_content_left <= '0;
      recent_bytes       <= '0;
      lead_idx           <= '0;
    end else begin
      lead_idx <= lead_idx_next;
      if (accept) begin
        phase              <= phase_next;
        file_position      <= file_position_next;
        header_count       <= header_count_next;
        box_size           <= box_size_next;
        box_type           <= box_type_next;
        skip_left          <= skip_left_next;
        outer_content_left <= outer_content_left_next;
        inner_content_left <= inner_content_left_next;
        recent_bytes       <= recent_bytes_next;
      end
    end
  end

  eil_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (buf_push),
    .push_data (buf_data),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (buf_head)
  );

  assign out_byte = buf_head.data;
  assign last     = buf_head.last;
  assign outcome  = buf_head.code;

endmodule

`default_nettype wire
